### rtl/sbfd_pkg.sv
// Package: constants, types and helpers shared by the frame decoder files.
`timescale 1ns / 1ps

package sbfd_pkg;

    localparam logic [7:0] START_BYTE   = 8'h0F;
    localparam logic [7:0] END_BYTE     = 8'h00;
    localparam int         FRAME_LEN    = 25;
    localparam int         POS_W        = 5;
    localparam logic [POS_W-1:0] END_POS = POS_W'(FRAME_LEN - 1);
    localparam int         STORE_BYTES  = FRAME_LEN - 2;
    localparam int         STORE_IDX_W  = $clog2(STORE_BYTES);
    localparam int         DATA_BYTES   = STORE_BYTES - 1;
    localparam int         DATA_W       = 8 * DATA_BYTES;
    localparam int         CHAN_W       = 11;
    localparam int         NUM_CHANNELS = 16;
    localparam int         CIDX_W       = 4;
    localparam logic [CIDX_W-1:0] LAST_CHANNEL = CIDX_W'(NUM_CHANNELS - 1);
    localparam int         LOST_BIT     = 2;
    localparam int         FS_BIT       = 3;
    localparam int         QUEUE_DEPTH  = 2;

    // One complete, checked frame waiting to be unpacked.
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              frame_lost;
        logic              failsafe;
    } frame_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Channel k occupies bits 11k .. 11k+10 of the packed channel bytes.
    function automatic logic [CHAN_W-1:0] channel_field(
        input logic [DATA_W-1:0] data,
        input logic [CIDX_W-1:0] k
    );
        logic [CHAN_W-1:0] value;
        value = data[CHAN_W * k +: CHAN_W];
        return value;
    endfunction

endpackage

### rtl/sbfd_byte_if.sv
// Interface: received byte channel.
`timescale 1ns / 1ps

interface sbfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

### rtl/sbfd_chan_if.sv
// Interface: decoded channel result channel.
`timescale 1ns / 1ps

interface sbfd_chan_if;
    logic        valid;
    logic        ready;
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic        frame_lost;
    logic        failsafe;
    logic        last;

    modport source (
        output valid, output channel_index, output channel_value,
        output frame_lost, output failsafe, output last, input ready
    );
    modport sink (
        input valid, input channel_index, input channel_value,
        input frame_lost, input failsafe, input last, output ready
    );
endinterface

### rtl/sbfd_front.sv
// Front end: hunt for the start byte, collect a frame, check the end byte.
`timescale 1ns / 1ps

module sbfd_front
    import sbfd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    sbfd_byte_if.sink     rx,
    input  queue_status_t q_status,
    output logic          push,
    output frame_t        frame
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       asm_reg [STORE_BYTES];
    logic             accept;
    logic             at_end;
    logic             store;

    // Stall only on the end byte while the queue has no room.
    assign at_end   = (pos_reg == END_POS);
    assign rx.ready = !(at_end && q_status.full);
    assign accept   = rx.valid && rx.ready;
    assign store    = accept && (pos_reg != '0) && !at_end;
    assign push     = accept && at_end && (rx.rx_byte == END_BYTE);

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (pos_reg == '0)
            begin
                pos_next = (rx.rx_byte == START_BYTE) ? POS_W'(1) : '0;
            end
            else if (at_end)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // Store bytes 1..23 at slot position - 1.
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            asm_reg[STORE_IDX_W'(pos_reg - POS_W'(1))] <= rx.rx_byte;
        end
    end

    always_comb
    begin
        for (int i = 0; i < DATA_BYTES; i++)
        begin
            frame.data[8 * i +: 8] = asm_reg[i];
        end
        frame.frame_lost = asm_reg[STORE_BYTES - 1][LOST_BIT];
        frame.failsafe   = asm_reg[STORE_BYTES - 1][FS_BIT];
    end

endmodule

### rtl/sbfd_frame_queue.sv
// Frame queue: holds checked frames between the front end and the unpacker.
`timescale 1ns / 1ps

module sbfd_frame_queue
    import sbfd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  frame_t        push_frame,
    input  logic          pop,
    output frame_t        head,
    output queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    frame_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

### rtl/sbfd_back.sv
// Unpacker: emit sixteen channel results per queued frame.
`timescale 1ns / 1ps

module sbfd_back
    import sbfd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  frame_t        head,
    input  queue_status_t q_status,
    output logic          pop,
    sbfd_chan_if.source   chan
);

    logic [CIDX_W-1:0] ch_reg;
    logic [CIDX_W-1:0] ch_next;
    logic              valid_reg;
    logic              valid_next;
    logic              load;

    logic [CIDX_W-1:0] index_reg;
    logic [CHAN_W-1:0] value_reg;
    logic              lost_reg;
    logic              fs_reg;
    logic              last_reg;

    // Advance whenever a frame is queued and the output register is free or being drained.
    assign load = !q_status.empty && (!valid_reg || chan.ready);
    assign pop  = load && (ch_reg == LAST_CHANNEL);

    always_comb
    begin
        ch_next    = ch_reg;
        valid_next = valid_reg;
        if (load)
        begin
            ch_next    = ch_reg + CIDX_W'(1);
            valid_next = 1'b1;
        end
        else if (chan.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg    <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            ch_reg    <= ch_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            index_reg <= ch_reg;
            value_reg <= channel_field(head.data, ch_reg);
            lost_reg  <= head.frame_lost;
            fs_reg    <= head.failsafe;
            last_reg  <= (ch_reg == LAST_CHANNEL);
        end
    end

    assign chan.valid         = valid_reg;
    assign chan.channel_index = index_reg;
    assign chan.channel_value = value_reg;
    assign chan.frame_lost    = lost_reg;
    assign chan.failsafe      = fs_reg;
    assign chan.last          = last_reg;

endmodule

### rtl/sbus_frame_decoder.sv
// Top level: S.BUS frame decoder, front end, frame queue and unpacker.
`timescale 1ns / 1ps

// The decoder takes one received byte per beat on rx and returns sixteen
// channel beats on chan for every good 25-byte frame. At frame position 0 it
// drops any byte other than the start byte 0x0F, so it locks onto the stream
// by itself; bytes 1 to 23 are stored, and byte 24 must be 0x00 or the frame
// is dropped with no output. A good frame is moved into a queue of
// QUEUE_DEPTH frames, and the unpacker emits channels 0 to 15 in order, each
// with the lost-frame and failsafe flags of byte 23, and last on channel 15.
// Rate: rx takes one byte every cycle; it stalls only on the end byte of a
// frame while QUEUE_DEPTH earlier frames are still being delivered. chan
// gives one beat per cycle while the sink is ready and a frame is queued, sixteen beats per frame,
// set by the single channel extraction mux ahead of the output register. The
// first channel of a frame appears once the queue holds it and it is loaded into the output register.

module sbus_frame_decoder
    import sbfd_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    sbfd_byte_if.sink   rx,
    sbfd_chan_if.source chan
);

    queue_status_t q_status;
    frame_t        push_frame;
    frame_t        head;
    logic          push;
    logic          pop;

    // Collect frames and hand over only those with a good end byte.
    sbfd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .q_status (q_status),
        .push     (push),
        .frame    (push_frame)
    );

    // Decouple byte intake from the result burst.
    sbfd_frame_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // Unpack the head frame one channel per beat.
    sbfd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .chan     (chan)
    );

    // A frame is never pushed into a full queue.
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("frame pushed into full queue");

    // A frame is never released from an empty queue.
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("frame popped from empty queue");

    // Byte intake stalls only for lack of queue room.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !rx.ready |-> q_status.full)
        else $error("rx stalled while queue has room");

endmodule

### sim/sbus_frame_decoder_checker.sv
// Checker: tracks frame assembly on the byte channel and scores every channel beat.
`timescale 1ns / 1ps

module sbus_frame_decoder_checker
    import sbfd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sbfd_byte_if rx,
    sbfd_chan_if chan,
    output int   fail_count,
    output int   pending
);

    typedef struct packed {
        logic [CIDX_W-1:0] index;
        logic [CHAN_W-1:0] value;
        logic              frame_lost;
        logic              failsafe;
        logic              last;
    } chan_beat_t;

    logic [7:0]       frame_buf [0:STORE_BYTES];
    logic [POS_W-1:0] frame_pos;
    chan_beat_t       channel_queue [$];
    int               mismatches;

    // Gather the eleven bits of channel k, least significant bit first from byte 1.
    function automatic logic [CHAN_W-1:0] unpack_channel(input int k);
        logic [CHAN_W-1:0] v;
        int                bitpos;
        for (int b = 0; b < CHAN_W; b++)
        begin
            bitpos = CHAN_W * k + b;
            v[b] = frame_buf[1 + bitpos / 8][bitpos % 8];
        end
        return v;
    endfunction

    task automatic take_byte(input logic [7:0] b);
        chan_beat_t beat;
        if (frame_pos >= POS_W'(FRAME_LEN))
            frame_pos = '0;
        // hunt for the start byte
        if (frame_pos == '0 && b != START_BYTE)
            return;
        if (frame_pos != END_POS)
        begin
            frame_buf[frame_pos] = b;
            frame_pos = frame_pos + 1'b1;
            return;
        end
        frame_pos = '0;
        if (b != END_BYTE)
            return;
        for (int k = 0; k < NUM_CHANNELS; k++)
        begin
            beat.index      = CIDX_W'(k);
            beat.value      = unpack_channel(k);
            beat.frame_lost = frame_buf[STORE_BYTES][LOST_BIT];
            beat.failsafe   = frame_buf[STORE_BYTES][FS_BIT];
            beat.last       = (k == NUM_CHANNELS - 1);
            channel_queue.push_back(beat);
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_beat();
        chan_beat_t want;
        if (channel_queue.size() == 0)
        begin
            $error("channel beat with nothing expected: index %0d value %0d",
                   chan.channel_index, chan.channel_value);
            mismatches++;
            return;
        end
        want = channel_queue.pop_front();
        compare_field("channel_index", 16'(want.index), 16'(chan.channel_index));
        compare_field("channel_value", 16'(want.value), 16'(chan.channel_value));
        compare_field("frame_lost", 16'(want.frame_lost), 16'(chan.frame_lost));
        compare_field("failsafe", 16'(want.failsafe), 16'(chan.failsafe));
        compare_field("last", 16'(want.last), 16'(chan.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pos = '0;
            channel_queue.delete();
            mismatches = 0;
        end
        else
        begin
            if (chan.valid && chan.ready)
                check_beat();
            if (rx.valid && rx.ready)
                take_byte(rx.rx_byte);
        end
        fail_count <= mismatches;
        pending    <= channel_queue.size();
    end

endmodule

### sim/sbus_frame_decoder_tb.sv
// Testbench top: clock, reset, byte stimulus, receiver back-pressure and verdict.
`timescale 1ns / 1ps

module sbus_frame_decoder_tb
    import sbfd_pkg::*;
();

    localparam int CYCLE_LIMIT      = 200000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 20;

    typedef enum int { FRAME_GOOD, FRAME_BAD_END } frame_kind_t;
    typedef enum int { FILL_RANDOM, FILL_ZERO, FILL_ONES } fill_style_t;

    logic clk;
    logic rst_n;

    sbfd_byte_if rx_bus ();
    sbfd_chan_if chan_bus ();

    int fail_count;
    int pending;

    // Knobs for the current phase; percentages of idle / stalled cycles.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int bytes_sent         = 0;
    int cycle_count        = 0;
    logic hold_active      = 1'b0;
    event hold_go;

    sbus_frame_decoder i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_bus),
        .chan  (chan_bus)
    );

    sbus_frame_decoder_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx_bus),
        .chan       (chan_bus),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Long receiver hold-off, counted here in its own process. Raise and drop
    // the flag on rising edges; the ready driver only looks at falling edges.
    initial
    begin
        forever
        begin
            @(hold_go);
            hold_active = 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clk);
            hold_active = 1'b0;
        end
    end

    // Receiver: stall at random per the phase, or hold off entirely on request.
    initial
    begin
        chan_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_active)
                chan_bus.ready <= 1'b0;
            else
                chan_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Offer one beat after a random idle gap and hold it until accepted.
    // Valid only drops when there is a gap, so it never toggles within a step.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            @(negedge clk);
            rx_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        rx_bus.valid   <= 1'b1;
        rx_bus.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_bus.ready);
    endtask

    task automatic drop_valid();
        @(negedge clk);
        rx_bus.valid <= 1'b0;
    endtask

    // Pause the sender until every expected channel beat has come out.
    // Pending is registered in the checker, so it is tested only after the clock has risen.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Send a whole 25-byte frame; the data fill picks zeros, ones or random.
    task automatic send_frame(input frame_kind_t kind);
        int          pick;
        fill_style_t style;
        logic [7:0]  fill;
        logic [7:0]  flags;
        pick  = $urandom_range(5);
        style = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_ONES : FILL_RANDOM;
        send_byte(START_BYTE);
        for (int i = 0; i < DATA_BYTES; i++)
        begin
            case (style)
                FILL_ZERO: fill = 8'h00;
                FILL_ONES: fill = 8'hFF;
                default:   fill = 8'($urandom_range(255));
            endcase
            send_byte(fill);
        end
        // Flag byte: only bits 2 and 3 matter; the rest follows the fill style.
        case (style)
            FILL_ZERO: flags = 8'h00;
            FILL_ONES: flags = 8'hFF;
            default:   flags = 8'($urandom_range(255));
        endcase
        send_byte(flags);
        if (kind == FRAME_BAD_END)
            send_byte(8'($urandom_range(1, 255)));
        else
            send_byte(END_BYTE);
        bytes_sent += FRAME_LEN;
    endtask

    // Line noise between frames; a stray start byte may slip in and desync.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom_range(255)));
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int budget);
        int start;
        int pick;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                send_frame(FRAME_GOOD);
            else if (pick < 92)
                send_frame(FRAME_BAD_END);
            else
                send_noise();
        end
        drop_valid();
        wait_drained();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        rx_bus.valid   = 1'b0;
        rx_bus.rx_byte = 8'h00;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a byte dropped while hunting, then a full-scale frame with
        // every channel at 2047 and all flag bits set, good end byte.
        send_byte(8'h00);
        send_byte(START_BYTE);
        for (int i = 0; i < DATA_BYTES; i++)
            send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(END_BYTE);
        drop_valid();
        wait_drained();

        // Random phases: no idling, idle sender, stalling receiver, both a little.
        run_phase(0, 0, 45);
        run_phase(78, 0, 45);
        run_phase(0, 78, 45);
        run_phase(8, 8, 45);

        // Back-pressure: hold the receiver off while frames keep coming so the
        // frame queue fills and the end byte stalls on rx.
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        -> hold_go;
        repeat (5) send_frame(FRAME_GOOD);
        drop_valid();
        wait_drained();

        // Catch any stray beats after the last expected one.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
